FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CHK(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(name, clk, rstn, prop)
`define ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

FILE: hw/rtl/dcbvp_pkg.sv
// Types and constants of the DC bus voltage protection block.
`timescale 1ns / 1ps
`default_nettype none
package dcbvp_pkg;

  localparam int unsigned VoltW = 14;
  localparam int unsigned DutyW = 7;
  localparam int unsigned CntW  = 6;
  localparam int unsigned IdxW  = 3;

  // 20.0 V undervoltage margin in 0.1 V units
  localparam logic [VoltW:0]   UNDER_MARGIN = 15'd200;
  localparam logic [CntW-1:0]  COUNT_MAX    = 6'd63;
  localparam logic [DutyW-1:0] DUTY_MAX     = 7'd100;

  localparam logic [VoltW-1:0] RELAY_ON_RST    = 14'd3224;
  localparam logic [VoltW-1:0] OVER_TRIP_RST   = 14'd7406;
  localparam logic [VoltW-1:0] REGEN_START_RST = 14'd6300;
  localparam logic [VoltW-1:0] REGEN_END_RST   = 14'd6180;
  localparam logic [DutyW-1:0] REGEN_DUTY_RST  = 7'd70;

  typedef enum logic [IdxW-1:0] {
    REG_RELAY_ON    = 3'd0,
    REG_OVER_TRIP   = 3'd1,
    REG_REGEN_START = 3'd2,
    REG_REGEN_END   = 3'd3,
    REG_REGEN_DUTY  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_UNDER = 2'd1,
    CAUSE_OVER  = 2'd2
  } trip_cause_e;

  typedef struct packed {
    logic [VoltW-1:0] relay_on_level;
    logic [VoltW-1:0] over_trip_level;
    logic [VoltW-1:0] regen_start_level;
    logic [VoltW-1:0] regen_end_level;
    logic [DutyW-1:0] regen_duty_percent;
  } cfg_t;

  typedef struct packed {
    logic            relay;
    logic [CntW-1:0] under_cnt;
    logic [CntW-1:0] over_cnt;
    logic            regen;
  } prot_state_t;

  typedef struct packed {
    logic             relay_closed;
    logic             trip;
    trip_cause_e      trip_cause;
    logic             regen_on;
    logic [DutyW-1:0] brake_duty;
  } result_t;

  // Saturating increment of a trip counter.
  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] c);
    return (c == COUNT_MAX) ? c : c + 6'd1;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dc_bus_voltage_protection_core.sv
// Top level of the DC bus voltage protection block.
// Path: a transferred sample is held in the input register, then its result in the result register (2-stage path).
// Throughput: one sample per clock while results are not stalled; a result stall reaches in_stall_o in the same cycle.
// Decision logic is a single pass of compares and 6-bit saturating counters per sample.
// Reset (async, active low): relay open, counters zero, regeneration off, config defaults.
// Stages empty after reset; configuration port is always ready.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dc_bus_voltage_protection_core #(
  parameter int unsigned TRIP_COUNT_LIMIT = 50  // 1..62
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [dcbvp_pkg::IdxW-1:0]  cfg_index_i,
  input  wire logic [dcbvp_pkg::VoltW-1:0] cfg_data_i,
  // sample input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [dcbvp_pkg::VoltW-1:0] bus_voltage_i,
  // result output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             relay_closed_o,
  output logic                             trip_o,
  output logic [1:0]                       trip_cause_o,
  output logic                             regen_on_o,
  output logic [dcbvp_pkg::DutyW-1:0]      brake_duty_o
);
  import dcbvp_pkg::*;

  cfg_t        cfg;
  prot_state_t state_q, state_d;
  result_t     res_q, res_d;

  logic             in_valid_q, in_valid_d;
  logic [VoltW-1:0] volt_q;
  logic             out_valid_q, out_valid_d;
  logic             in_xfer;
  logic             advance;

  dcbvp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dcbvp_eval #(
    .TripCountLimit (TRIP_COUNT_LIMIT)
  ) u_eval (
    .volt_i   (volt_q),
    .cfg_i    (cfg),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // The sample in the input register moves on whenever the result register
  // is empty or being drained; state is committed only on that move.
  assign advance     = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o  = in_valid_q & ~advance;
  assign in_xfer     = in_valid_i & ~in_stall_o;
  assign in_valid_d  = in_xfer | (in_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      volt_q <= bus_voltage_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign relay_closed_o = res_q.relay_closed;
  assign trip_o         = res_q.trip;
  assign trip_cause_o   = res_q.trip_cause;
  assign regen_on_o     = res_q.regen_on;
  assign brake_duty_o   = res_q.brake_duty;

  // relay never reopens once closed
  `ASSERT_CHK(a_relay_sticky, clk_i, rst_ni, state_q.relay |=> state_q.relay)
  // a trip always carries a cause, and no cause without a trip
  `ASSERT_CHK(a_trip_cause, clk_i, rst_ni,
              out_valid_q |-> (res_q.trip == (res_q.trip_cause != CAUSE_NONE)))
  // undervoltage can only trip with the relay closed
  `ASSERT_CHK(a_under_relay, clk_i, rst_ni,
              (out_valid_q && (res_q.trip_cause == CAUSE_UNDER)) |-> res_q.relay_closed)
  // brake duty only while regenerating, and never above full scale
  `ASSERT_NEVER(a_duty_off, clk_i, rst_ni,
                out_valid_q && !res_q.regen_on && (res_q.brake_duty != '0))
  `ASSERT_NEVER(a_duty_max, clk_i, rst_ni, out_valid_q && (res_q.brake_duty > DUTY_MAX))

endmodule
`default_nettype wire

FILE: hw/rtl/dcbvp_cfg_regs.sv
// Configuration register file of the DC bus voltage protection block.
`timescale 1ns / 1ps
`default_nettype none
module dcbvp_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [dcbvp_pkg::IdxW-1:0]  cfg_index_i,
  input  wire logic [dcbvp_pkg::VoltW-1:0] cfg_data_i,
  output dcbvp_pkg::cfg_t                  cfg_o
);
  import dcbvp_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_RELAY_ON:    cfg_d.relay_on_level     = cfg_data_i;
        REG_OVER_TRIP:   cfg_d.over_trip_level    = cfg_data_i;
        REG_REGEN_START: cfg_d.regen_start_level  = cfg_data_i;
        REG_REGEN_END:   cfg_d.regen_end_level    = cfg_data_i;
        REG_REGEN_DUTY:  cfg_d.regen_duty_percent = cfg_data_i[DutyW-1:0];
        default:         cfg_d = cfg_q;  // unmapped index: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.relay_on_level     <= RELAY_ON_RST;
      cfg_q.over_trip_level    <= OVER_TRIP_RST;
      cfg_q.regen_start_level  <= REGEN_START_RST;
      cfg_q.regen_end_level    <= REGEN_END_RST;
      cfg_q.regen_duty_percent <= REGEN_DUTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

FILE: hw/rtl/dcbvp_eval.sv
// Per-sample protection decision: relay, trip counters and regeneration.
`timescale 1ns / 1ps
`default_nettype none
module dcbvp_eval #(
  parameter int unsigned TripCountLimit = 50
) (
  input  wire logic [dcbvp_pkg::VoltW-1:0] volt_i,
  input  dcbvp_pkg::cfg_t                  cfg_i,
  input  dcbvp_pkg::prot_state_t           state_i,
  output dcbvp_pkg::prot_state_t           state_o,
  output dcbvp_pkg::result_t               result_o
);
  import dcbvp_pkg::*;

  localparam logic [CntW-1:0] TripLimit = CntW'(TripCountLimit);

  logic             under_hit;
  logic             trip_under;
  logic             trip_over;
  logic             regen_nxt;
  logic [CntW-1:0]  under_inc;
  logic [CntW-1:0]  over_inc;
  logic [DutyW-1:0] duty_clip;

  assign under_hit = ({1'b0, volt_i} + UNDER_MARGIN) < {1'b0, cfg_i.relay_on_level};
  assign under_inc = sat_inc(state_i.under_cnt);
  assign over_inc  = sat_inc(state_i.over_cnt);

  always_comb begin
    state_o    = state_i;
    trip_under = 1'b0;
    trip_over  = 1'b0;
    regen_nxt  = state_i.regen;

    // relay closes once; undervoltage is only watched from the next sample
    if (!state_i.relay) begin
      state_o.relay = volt_i > cfg_i.relay_on_level;
    end else if (under_hit) begin
      state_o.under_cnt = under_inc;
      trip_under        = under_inc > TripLimit;
    end else begin
      state_o.under_cnt = '0;
    end

    if (!trip_under) begin
      if (volt_i > cfg_i.over_trip_level) begin
        state_o.over_cnt = over_inc;
        trip_over        = over_inc > TripLimit;
      end else begin
        state_o.over_cnt = '0;
      end
    end

    // a tripping sample holds the regeneration state
    if (!trip_under && !trip_over) begin
      if (volt_i > cfg_i.regen_start_level) begin
        regen_nxt = 1'b1;
      end
      if (regen_nxt && (volt_i < cfg_i.regen_end_level)) begin
        regen_nxt = 1'b0;
      end
    end
    state_o.regen = regen_nxt;
  end

  assign duty_clip = (cfg_i.regen_duty_percent > DUTY_MAX) ? DUTY_MAX
                                                           : cfg_i.regen_duty_percent;

  always_comb begin
    result_o.relay_closed = state_o.relay;
    result_o.trip         = trip_under | trip_over;
    priority if (trip_under) begin
      result_o.trip_cause = CAUSE_UNDER;
    end else if (trip_over) begin
      result_o.trip_cause = CAUSE_OVER;
    end else begin
      result_o.trip_cause = CAUSE_NONE;
    end
    result_o.regen_on   = state_o.regen;
    result_o.brake_duty = state_o.regen ? duty_clip : '0;
  end

endmodule
`default_nettype wire
